// ===== src/label_overlap_purity_macros.svh =====
// Assertion macros used by the checks in the top module.
`ifndef LABEL_OVERLAP_PURITY_MACROS_SVH
`define LABEL_OVERLAP_PURITY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LOP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("label_overlap_purity check failed");

// Next-cycle implication, checked outside reset.
`define LOP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("label_overlap_purity check failed");

`endif

// ===== src/lop_pkg.sv =====
// Types and constants shared by the label overlap purity block.
`default_nettype none
package lop_pkg;

  localparam int NumLabelsDef = 256;
  localparam int CountBitsDef = 24;
  localparam int LabW         = 8;
  localparam int OutW         = 24;
  localparam int PctW         = 7;

  typedef enum logic [1:0] {
    CMD_ACC = 2'd0,
    CMD_ROW = 2'd1,
    CMD_COL = 2'd2,
    CMD_CLR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ACC = 2'd0,
    OP_QRY = 2'd1,
    OP_CLR = 2'd2
  } op_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [LabW-1:0] ref_label;
    logic [LabW-1:0] seg_label;
  } in_t;

  typedef struct packed {
    logic            present;
    logic [LabW-1:0] best_label;
    logic [OutW-1:0] max_overlap;
    logic [OutW-1:0] total_overlap;
    logic [PctW-1:0] percent;
  } out_t;

  typedef struct packed {
    op_e             op;
    logic            by_row;
    logic            absent;
    logic [LabW-1:0] ref_label;
    logic [LabW-1:0] seg_label;
  } job_t;

endpackage
`default_nettype wire

// ===== src/label_overlap_purity.sv =====
// Label overlap purity: joint label count matrix with row and column queries.
// A pixel word passes through the back end as a memory read, then a write.
// A query: one read per nonzero label, a multiply, a 7-step divide; an absent label skips the scan.
// A clear sweeps every memory entry, one entry per cycle.
// After reset the same sweep runs first; words are queued but not executed until it ends.
// A two-entry queue lets the input accept words while the back end works or a result waits.
`default_nettype none
`include "label_overlap_purity_macros.svh"
module label_overlap_purity import lop_pkg::*; #(
  parameter int NUM_LABELS = NumLabelsDef,
  parameter int COUNT_BITS = CountBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic job_valid, job_ready;
  job_t job;

  lop_front #(
    .NumLabels(NUM_LABELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .job_valid_o(job_valid),
    .job_ready_i(job_ready),
    .job_o      (job)
  );

  lop_back #(
    .NumLabels(NUM_LABELS),
    .CountBits(COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_ready_o(job_ready),
    .job_i      (job),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  `LOP_ASSERT_IMP(a_full_has_head, !in_ready_o, job_valid)
  `LOP_ASSERT_NXT(a_one_job_at_a_time, job_valid && job_ready, !job_ready)
  `LOP_ASSERT_NXT(a_head_holds, job_valid && !job_ready, job_valid && $stable(job))

endmodule
`default_nettype wire

// ===== src/lop_front.sv =====
// Front end: accepts words, classifies them and queues jobs for the back end.
`default_nettype none
module lop_front import lop_pkg::*; #(
  parameter int NumLabels = NumLabelsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      job_valid_o,
  input  wire logic job_ready_i,
  output job_t      job_o
);

  localparam logic [LabW:0] NumL = (LabW+1)'(NumLabels);

  job_t       job_c;
  logic       keep;
  job_t       fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  always_comb begin
    job_c.op        = OP_ACC;
    job_c.by_row    = 1'b0;
    job_c.absent    = 1'b0;
    job_c.ref_label = in_data_i.ref_label;
    job_c.seg_label = in_data_i.seg_label;
    keep            = 1'b1;
    case (in_data_i.cmd)
      CMD_ACC: begin
        keep = (in_data_i.ref_label != '0) && (in_data_i.seg_label != '0) &&
               ({1'b0, in_data_i.ref_label} < NumL) &&
               ({1'b0, in_data_i.seg_label} < NumL);
      end
      CMD_ROW: begin
        job_c.op     = OP_QRY;
        job_c.by_row = 1'b1;
        job_c.absent = (in_data_i.ref_label == '0) || ({1'b0, in_data_i.ref_label} >= NumL);
      end
      CMD_COL: begin
        job_c.op     = OP_QRY;
        job_c.absent = (in_data_i.seg_label == '0) || ({1'b0, in_data_i.seg_label} >= NumL);
      end
      CMD_CLR: begin
        job_c.op = OP_CLR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rd_q];
  assign push        = in_valid_i && in_ready_o && keep;
  assign pop         = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= job_c;
    end
  end

endmodule
`default_nettype wire

// ===== src/lop_back.sv =====
// Back end: count memory, row and column scans, percent divider, result register.
`default_nettype none
module lop_back import lop_pkg::*; #(
  parameter int NumLabels = NumLabelsDef,
  parameter int CountBits = CountBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  wire job_t job_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int LB = $clog2(NumLabels);
  localparam int AW = 2 * LB;
  localparam int OB = (CountBits < OutW) ? CountBits : OutW;
  localparam logic [CountBits-1:0] Ceil = '1;
  localparam logic [OutW-1:0] OutCeil = OutW'((64'd1 << OB) - 64'd1);
  localparam logic [OutW-1:0] OutMax = '1;
  localparam logic [LB-1:0] LastLab = LB'(NumLabels - 1);

  typedef enum logic [7:0] {
    ST_CLR   = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_ACC   = 8'b00000100,
    ST_SCAN  = 8'b00001000,
    ST_DRAIN = 8'b00010000,
    ST_MUL   = 8'b00100000,
    ST_DIV   = 8'b01000000,
    ST_RES   = 8'b10000000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [LB-1:0]       other_q, other_d;
  logic [LB-1:0]       label_q, label_d;
  logic                by_row_q, by_row_d;
  logic [AW-1:0]       waddr_q, waddr_d;
  logic [CountBits-1:0] best_q, best_d;
  logic [LB-1:0]       blab_q, blab_d;
  logic [OutW-1:0]     tot_q, tot_d;
  logic                scan_vld_q, scan_vld_d;
  logic [LB-1:0]       tag_q, tag_d;
  logic [31:0]         rem_q, rem_d;
  logic [PctW-1:0]     quo_q, quo_d;
  logic [2:0]          k_q, k_d;
  logic                out_vld_q, out_vld_d;
  out_t                out_q, out_d;

  logic [CountBits-1:0] mem_q [2**AW];
  logic [CountBits-1:0] rdata_q;
  logic [AW-1:0]        raddr, waddr;
  logic [CountBits-1:0] wdata;
  logic                 we;
  logic [32:0]          sum;
  logic [OutW-1:0]      max_s;
  logic [31:0]          tsh;

  always_comb begin
    sum   = 33'(tot_q) + 33'(rdata_q);
    max_s = (33'(best_q) > 33'(OutMax)) ? OutMax : OutW'(best_q);
    tsh   = 32'(tot_q) << k_q;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    other_d    = other_q;
    label_d    = label_q;
    by_row_d   = by_row_q;
    waddr_d    = waddr_q;
    best_d     = best_q;
    blab_d     = blab_q;
    tot_d      = tot_q;
    scan_vld_d = 1'b0;
    tag_d      = tag_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    k_d        = k_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    job_ready_o = 1'b0;
    raddr      = by_row_q ? {label_q, other_q} : {other_q, label_q};
    waddr      = waddr_q;
    wdata      = '0;
    we         = 1'b0;

    if (scan_vld_q) begin
      tot_d = (sum > 33'(OutCeil)) ? OutCeil : sum[OutW-1:0];
      if (rdata_q > best_q) begin
        best_d = rdata_q;
        blab_d = tag_q;
      end
    end

    case (state_q)
      ST_CLR: begin
        we    = 1'b1;
        waddr = cnt_q;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        job_ready_o = 1'b1;
        raddr       = {job_i.ref_label[LB-1:0], job_i.seg_label[LB-1:0]};
        if (job_valid_i) begin
          case (job_i.op)
            OP_ACC: begin
              waddr_d = raddr;
              state_d = ST_ACC;
            end
            OP_QRY: begin
              by_row_d = job_i.by_row;
              label_d  = job_i.by_row ? job_i.ref_label[LB-1:0] : job_i.seg_label[LB-1:0];
              other_d  = LB'(1);
              best_d   = '0;
              blab_d   = '0;
              tot_d    = '0;
              state_d  = job_i.absent ? ST_MUL : ST_SCAN;
            end
            OP_CLR: begin
              cnt_d   = '0;
              state_d = ST_CLR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ACC: begin
        we      = 1'b1;
        wdata   = (rdata_q == Ceil) ? rdata_q : rdata_q + CountBits'(1);
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        scan_vld_d = 1'b1;
        tag_d      = other_q;
        if (other_q == LastLab) begin
          state_d = ST_DRAIN;
        end else begin
          other_d = other_q + LB'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        rem_d   = 32'(max_s) * 32'd100;
        quo_d   = '0;
        k_d     = 3'd6;
        state_d = (tot_q == '0) ? ST_RES : ST_DIV;
      end
      ST_DIV: begin
        if (rem_q >= tsh) begin
          rem_d      = rem_q - tsh;
          quo_d[k_q] = 1'b1;
        end
        if (k_q == 3'd0) begin
          state_d = ST_RES;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      ST_RES: begin
        if (!out_vld_q || out_ready_i) begin
          out_d.present       = (tot_q != '0);
          out_d.best_label    = LabW'(blab_q);
          out_d.max_overlap   = max_s;
          out_d.total_overlap = tot_q;
          out_d.percent       = quo_q;
          out_vld_d           = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      cnt_q      <= '0;
      scan_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      scan_vld_q <= scan_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    other_q  <= other_d;
    label_q  <= label_d;
    by_row_q <= by_row_d;
    waddr_q  <= waddr_d;
    best_q   <= best_d;
    blab_q   <= blab_d;
    tot_q    <= tot_d;
    tag_q    <= tag_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    k_q      <= k_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== tb/tb_label_overlap_purity.sv =====
// Testbench for label_overlap_purity: random pixel and query words plus directed clears checked against a predictor.
`default_nettype none
module tb_label_overlap_purity;
  import lop_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  label_overlap_purity dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_t         pending_words[$];
  out_t        expected_answers[$];
  int unsigned joint_counts[256][256];
  int          fail_count = 0;
  int          words_taken = 0;
  int          answers_seen = 0;
  int          clears_seen = 0;
  bit          in_fire = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic out_t overlap_answer(logic [7:0] label, bit by_row);
    out_t        ans;
    longint      total;
    int unsigned best;
    int unsigned c;
    logic [7:0]  best_lab;
    ans = '0;
    total = 0;
    best = 0;
    best_lab = '0;
    if (label == 8'd0) return ans;
    for (int k = 1; k < 256; k++) begin
      c = by_row ? joint_counts[label][k] : joint_counts[k][label];
      total += c;
      if (c > best) begin
        best = c;
        best_lab = k[7:0];
      end
    end
    if (total == 0) return ans;
    if (total > 64'hFFFFFF) total = 64'hFFFFFF;
    ans.present       = 1'b1;
    ans.best_label    = best_lab;
    ans.max_overlap   = best[23:0];
    ans.total_overlap = total[23:0];
    ans.percent       = 7'((64'd100 * best) / total);
    return ans;
  endfunction

  task automatic expect_answer(out_t a);
    expected_answers = {expected_answers, a};
  endtask

  task automatic queue_word(in_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic apply_word(in_t w);
    case (w.cmd)
      CMD_ACC: begin
        if (w.ref_label != 0 && w.seg_label != 0 &&
            joint_counts[w.ref_label][w.seg_label] < 32'hFFFFFF)
          joint_counts[w.ref_label][w.seg_label]++;
      end
      CMD_ROW: expect_answer(overlap_answer(w.ref_label, 1'b1));
      CMD_COL: expect_answer(overlap_answer(w.seg_label, 1'b0));
      default: begin
        foreach (joint_counts[i, j]) joint_counts[i][j] = 0;
        clears_seen++;
      end
    endcase
  endtask

  function automatic in_t make_word(cmd_e c, int r, int s);
    in_t w;
    w.cmd = c;
    w.ref_label = r[7:0];
    w.seg_label = s[7:0];
    return w;
  endfunction

  function automatic int some_label();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(0, 255);
  endfunction

  // Sender: accept at the rising edge, present the next word at the falling edge.
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) begin
      apply_word(in_data_i);
      words_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (in_fire || !in_valid_i)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_data_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, compare each answer with the oldest prediction.
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      out_gap = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        $error("unexpected answer word %h", out_data_o);
        fail_count++;
      end else begin
        e = expected_answers.pop_front();
        if (out_data_o.present !== e.present) begin
          $error("present: expected %0d actual %0d", e.present, out_data_o.present);
          fail_count++;
        end
        if (out_data_o.best_label !== e.best_label) begin
          $error("best_label: expected %0d actual %0d", e.best_label, out_data_o.best_label);
          fail_count++;
        end
        if (out_data_o.max_overlap !== e.max_overlap) begin
          $error("max_overlap: expected %0d actual %0d", e.max_overlap,
                 out_data_o.max_overlap);
          fail_count++;
        end
        if (out_data_o.total_overlap !== e.total_overlap) begin
          $error("total_overlap: expected %0d actual %0d", e.total_overlap,
                 out_data_o.total_overlap);
          fail_count++;
        end
        if (out_data_o.percent !== e.percent) begin
          $error("percent: expected %0d actual %0d", e.percent, out_data_o.percent);
          fail_count++;
        end
      end
    end
  end

  task automatic push_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        queue_word(make_word(CMD_ACC, some_label(), some_label()));
      else if (r < 85)
        queue_word(make_word(CMD_ROW, some_label(), $urandom_range(0, 255)));
      else
        queue_word(make_word(CMD_COL, $urandom_range(0, 255), some_label()));
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || expected_answers.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    foreach (joint_counts[i, j]) joint_counts[i][j] = 0;
    // Corners: background pixels, label extremes, absent labels, clear.
    queue_word(make_word(CMD_ACC, 0, 5));
    queue_word(make_word(CMD_ACC, 5, 0));
    queue_word(make_word(CMD_ACC, 0, 0));
    queue_word(make_word(CMD_ACC, 255, 255));
    queue_word(make_word(CMD_ACC, 255, 1));
    queue_word(make_word(CMD_ACC, 1, 255));
    queue_word(make_word(CMD_ACC, 1, 1));
    queue_word(make_word(CMD_ACC, 1, 170));
    queue_word(make_word(CMD_ACC, 170, 85));
    queue_word(make_word(CMD_ROW, 0, 0));
    queue_word(make_word(CMD_COL, 0, 0));
    queue_word(make_word(CMD_ROW, 255, 0));
    queue_word(make_word(CMD_COL, 0, 255));
    queue_word(make_word(CMD_ROW, 1, 255));
    queue_word(make_word(CMD_COL, 255, 1));
    queue_word(make_word(CMD_ROW, 5, 0));
    queue_word(make_word(CMD_COL, 0, 85));
    queue_word(make_word(CMD_CLR, 255, 255));
    queue_word(make_word(CMD_ROW, 1, 0));
    queue_word(make_word(CMD_COL, 0, 255));
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    push_random(450);
    wait_drained();
    push_random(300);
    queue_word(make_word(CMD_CLR, $urandom_range(0, 255), $urandom_range(0, 255)));
    push_random(250);
    queue_word(make_word(CMD_ROW, 2, 0));
    queue_word(make_word(CMD_COL, 0, 3));
    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("Run covered %0d words, %0d checked answers, %0d clears.",
             words_taken, answers_seen, clears_seen);
    if (expected_answers.size() > 0) fail_count++;
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
